### hw/rtl/pse_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the printable string extractor.
// No dependencies; used by pse_cell, pse_chain and printable_string_extractor.
package pse_pkg;

   // Depth of the hold chain (bytes of an open run not yet emitted)
   localparam int HOLD_DEPTH = 63;
   localparam int RUN_W      = 6;
   localparam int BYTE_W     = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BYTE_W-1:0] TAB_CHAR  = 8'h09;
   localparam logic [BYTE_W-1:0] LINE_END  = 8'h0A;
   localparam logic [BYTE_W-1:0] PRINT_LO  = 8'h20;
   localparam logic [BYTE_W-1:0] PRINT_HI  = 8'h7E;
   localparam logic [RUN_W-1:0]  RUN_MAX   = {RUN_W{1'b1}};
   localparam logic [RUN_W-1:0]  MIN_RUN_RESET = 6'd4;

   // Control from the sequencer to the hold chain
   typedef struct packed {
      logic clear;
      logic append;
      logic shift;
   } chain_ctl_type;

   // Status from the hold chain to the sequencer
   typedef struct packed {
      logic [BYTE_W-1:0] head_data;
      logic              head_valid;
      logic              second_valid;
   } chain_sts_type;

   // Test a byte for printable ASCII or tab
   function automatic logic is_printable(input logic [BYTE_W-1:0] b);
      return (b inside {[PRINT_LO:PRINT_HI], TAB_CHAR});
   endfunction

   // Effective threshold: zero acts as one, capped at the hold depth
   function automatic logic [RUN_W-1:0] eff_threshold(input logic [RUN_W-1:0] m);
      logic [RUN_W-1:0] t;
      t = (m == '0) ? RUN_W'(1) : m;
      if (t > RUN_W'(HOLD_DEPTH)) begin
         t = RUN_W'(HOLD_DEPTH);
      end
      return t;
   endfunction

endpackage

### hw/rtl/printable_string_extractor.sv
`timescale 1ns / 1ps
// Printable string extractor: takes one byte per req word and returns the
// bytes of printable runs of at least min_run bytes, each run closed by a
// newline word. A request is taken while the block is idle; it then holds off
// further requests until every result word it causes has been issued (a
// pass-through byte and/or newline, or a flush of the held run, which is
// drained from the head of the hold chain one byte per cycle unless rsp_ready
// stalls it). The hold chain is a row of 63 cells; it needs no clearing
// pass after reset. Register min_run sits at byte address 0 (reset 4).
// Depends on pse_pkg and pse_chain.
module printable_string_extractor (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pse_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic                           req_end_of_buffer,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pse_pkg::BYTE_W-1:0]     rsp_out_char,
   output logic                           rsp_is_line_end,
   output logic                           rsp_last_of_burst,
   // register port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pse_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pse_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pse_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import pse_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;
   localparam logic REG_MIN_RUN = 1'b0;

   // ---------------- register port ----------------
   logic [RUN_W-1:0] min_run_ff, min_run_in;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   // Write min_run at its slot, ignore other addresses
   always_comb begin
      min_run_in = min_run_ff;
      if (csr_wr && csr_paddr[2] == REG_MIN_RUN) begin
         min_run_in = csr_pwdata[RUN_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_MIN_RUN) begin
         csr_prdata = {{(CSR_DATA_W-RUN_W){1'b0}}, min_run_ff};
      end
   end

   // ---------------- run state and sequencer ----------------
   logic             state_ff, state_in;
   logic [RUN_W-1:0] run_len_ff, run_len_in;
   logic             passing_ff, passing_in;
   logic             line_emit_ff, line_emit_in;
   logic             char_pend_ff, char_pend_in;
   logic             flush_pend_ff, flush_pend_in;
   logic             nl_pend_ff, nl_pend_in;
   logic [BYTE_W-1:0] char_ff, char_in;

   logic [BYTE_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_le_ff, rsp_le_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_valid_ff, rsp_valid_in;

   chain_ctl_type chain_ctl;
   chain_sts_type chain_sts;

   logic             accept, printable, last, emit, slot_free;
   logic [RUN_W-1:0] thr, run_inc, run_mid;
   logic             pass_mid, le_mid, run_open, do_flush, do_nl;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign printable = is_printable(req_data_byte);
   assign last      = req_end_of_buffer;
   assign thr       = eff_threshold(min_run_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit      = (state_ff == ST_BUSY) && slot_free;

   // Work out the effect of one byte on the run
   always_comb begin
      run_inc  = run_len_ff + RUN_W'(1);
      run_mid  = run_len_ff;
      pass_mid = passing_ff;
      le_mid   = line_emit_ff;
      do_flush = 1'b0;
      do_nl    = 1'b0;
      if (printable) begin
         if (passing_ff) begin
            if (run_len_ff != RUN_MAX) begin
               run_mid = run_inc;
            end
         end else begin
            run_mid = run_inc;
            if (run_inc >= thr) begin
               pass_mid = 1'b1;
               do_flush = 1'b1;
            end
         end
      end else begin
         if (passing_ff) begin
            do_nl  = 1'b1;
            le_mid = 1'b1;
         end
         run_mid  = '0;
         pass_mid = 1'b0;
      end
      run_open = (run_mid != '0);
      // Close the open run at the end of the buffer
      if (last && run_open) begin
         if (pass_mid) begin
            do_nl = 1'b1;
         end else if (!le_mid) begin
            do_flush = 1'b1;
            do_nl    = 1'b1;
         end
      end
   end

   // Hold chain control: clear on a closed run or a dropped short run
   always_comb begin
      chain_ctl.clear  = accept && (!printable || (last && !do_flush));
      chain_ctl.append = accept && printable && !passing_ff;
      chain_ctl.shift  = emit && !char_pend_ff && flush_pend_ff;
   end

   pse_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .ctl     (chain_ctl),
      .wr_data (req_data_byte),
      .sts     (chain_sts)
   );

   // Advance the run state on accept, drain pending words while busy
   always_comb begin
      state_in      = state_ff;
      run_len_in    = run_len_ff;
      passing_in    = passing_ff;
      line_emit_in  = line_emit_ff;
      char_pend_in  = char_pend_ff;
      flush_pend_in = flush_pend_ff;
      nl_pend_in    = nl_pend_ff;
      char_in       = char_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_le_in     = rsp_le_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         char_in       = req_data_byte;
         char_pend_in  = printable && passing_ff;
         flush_pend_in = do_flush;
         nl_pend_in    = do_nl;
         run_len_in    = last ? '0 : run_mid;
         passing_in    = last ? 1'b0 : pass_mid;
         line_emit_in  = last ? 1'b0 : le_mid;
         state_in      = (printable && passing_ff) || do_flush || do_nl ? ST_BUSY : ST_IDLE;
      end else if (emit) begin
         rsp_valid_in = 1'b1;
         if (char_pend_ff) begin
            rsp_char_in  = char_ff;
            rsp_le_in    = 1'b0;
            rsp_last_in  = !nl_pend_ff;
            char_pend_in = 1'b0;
            state_in     = nl_pend_ff ? ST_BUSY : ST_IDLE;
         end else if (flush_pend_ff) begin
            rsp_char_in   = chain_sts.head_data;
            rsp_le_in     = 1'b0;
            rsp_last_in   = !chain_sts.second_valid && !nl_pend_ff;
            flush_pend_in = chain_sts.second_valid;
            state_in      = (chain_sts.second_valid || nl_pend_ff) ? ST_BUSY : ST_IDLE;
         end else begin
            rsp_char_in = LINE_END;
            rsp_le_in   = 1'b1;
            rsp_last_in = 1'b1;
            nl_pend_in  = 1'b0;
            state_in    = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         run_len_ff    <= '0;
         passing_ff    <= 1'b0;
         line_emit_ff  <= 1'b0;
         char_pend_ff  <= 1'b0;
         flush_pend_ff <= 1'b0;
         nl_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         min_run_ff    <= MIN_RUN_RESET;
      end else begin
         state_ff      <= state_in;
         run_len_ff    <= run_len_in;
         passing_ff    <= passing_in;
         line_emit_ff  <= line_emit_in;
         char_pend_ff  <= char_pend_in;
         flush_pend_ff <= flush_pend_in;
         nl_pend_ff    <= nl_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         min_run_ff    <= min_run_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      rsp_char_ff <= rsp_char_in;
      rsp_le_ff   <= rsp_le_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_char      = rsp_char_ff;
   assign rsp_is_line_end   = rsp_le_ff;
   assign rsp_last_of_burst = rsp_last_ff;

`ifndef SYNTHESIS
   // Busy always has a word left to send
   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BUSY |-> (char_pend_ff || flush_pend_ff || nl_pend_ff))
      else $error("busy with nothing pending");

   // A pending flush always finds a held byte at the head
   a_flush_has_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUSY && flush_pend_ff) |-> chain_sts.head_valid)
      else $error("flush from empty hold chain");

   // Held bytes are packed from the head
   a_chain_packed: assert property (@(posedge clock) disable iff (reset)
      !chain_sts.head_valid |-> !chain_sts.second_valid)
      else $error("hold chain has a gap");

   // While passing through and idle, nothing is held
   a_pass_empty: assert property (@(posedge clock) disable iff (reset)
      (passing_ff && state_ff == ST_IDLE) |-> !chain_sts.head_valid)
      else $error("bytes held while passing through");
`endif

endmodule

### hw/rtl/pse_cell.sv
`timescale 1ns / 1ps
// One cell of the hold chain: a byte and its valid bit.
// Depends on pse_pkg.
module pse_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  pse_pkg::chain_ctl_type        ctl,
   input  logic [pse_pkg::BYTE_W-1:0]    wr_data,
   input  logic                          prev_valid,
   input  logic [pse_pkg::BYTE_W-1:0]    next_data,
   input  logic                          next_valid,
   output logic [pse_pkg::BYTE_W-1:0]    data,
   output logic                          valid
);
   import pse_pkg::*;

   logic [BYTE_W-1:0] data_ff, data_in;
   logic              valid_ff, valid_in;

   // Clear, shift towards the head, or take the appended byte at the fill edge
   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.shift) begin
         data_in  = next_data;
         valid_in = next_valid;
      end else if (ctl.append && !valid_ff && prev_valid) begin
         data_in  = wr_data;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign valid = valid_ff;

endmodule

### hw/rtl/pse_chain.sv
`timescale 1ns / 1ps
// Hold chain: a row of pse_cell, filled at the first empty cell, drained at cell 0.
// Depends on pse_pkg and pse_cell.
module pse_chain (
   input  logic                       clock,
   input  logic                       reset,
   input  pse_pkg::chain_ctl_type     ctl,
   input  logic [pse_pkg::BYTE_W-1:0] wr_data,
   output pse_pkg::chain_sts_type     sts
);
   import pse_pkg::*;

   logic [BYTE_W-1:0] cell_data  [0:HOLD_DEPTH];
   logic              cell_valid [0:HOLD_DEPTH];
   logic              prev_valid [0:HOLD_DEPTH-1];

   // Past the tail the chain reads as empty
   assign cell_data[HOLD_DEPTH]  = '0;
   assign cell_valid[HOLD_DEPTH] = 1'b0;

   genvar i;
   generate
      for (i = 0; i < HOLD_DEPTH; i++) begin : g_cell
         if (i == 0) begin : g_head
            assign prev_valid[i] = 1'b1;
         end else begin : g_body
            assign prev_valid[i] = cell_valid[i-1];
         end
         pse_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .wr_data    (wr_data),
            .prev_valid (prev_valid[i]),
            .next_data  (cell_data[i+1]),
            .next_valid (cell_valid[i+1]),
            .data       (cell_data[i]),
            .valid      (cell_valid[i])
         );
      end
   endgenerate

   assign sts.head_data    = cell_data[0];
   assign sts.head_valid   = cell_valid[0];
   assign sts.second_valid = cell_valid[1];

endmodule
